[rtl/jet_priority_sorted_table_unit_defines.svh]
// assertion macros for the jet priority table
`ifndef JET_PRIORITY_SORTED_TABLE_UNIT_DEFINES_SVH
`define JET_PRIORITY_SORTED_TABLE_UNIT_DEFINES_SVH

`define JPST_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("label failed");

`define JPST_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("label failed");

`endif

[rtl/jpst_pkg.sv]
// ----------------------------------------------------------------------------
// jpst_pkg
// types and constants shared by the jet priority table
// ----------------------------------------------------------------------------
package jpst_pkg;

    localparam int MAX_JETS = 16;
    localparam int MOM_BITS = 24;
    localparam int IDX_BITS = 4;
    localparam int CNT_BITS = 5;
    localparam int KEY_BITS = 50;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [MOM_BITS-1:0] jet_px;
        logic signed [MOM_BITS-1:0] jet_py;
        logic signed [MOM_BITS-1:0] jet_pz;
        logic [MOM_BITS-2:0]        jet_energy;
        logic [7:0]                 jet_tag;
        logic                       jet_taggable;
        logic [IDX_BITS-1:0]        read_index;
    } jet_in_t;

    typedef struct packed {
        logic signed [MOM_BITS-1:0] out_px;
        logic signed [MOM_BITS-1:0] out_py;
        logic signed [MOM_BITS-1:0] out_pz;
        logic [MOM_BITS-2:0]        out_energy;
        logic [7:0]                 out_tag;
        logic                       out_taggable;
        logic [CNT_BITS-1:0]        jet_count;
        logic [CNT_BITS-1:0]        bjet_count;
        logic [CNT_BITS-1:0]        insert_position;
        logic                       error_flag;
    } jet_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic square;
        logic sum;
        logic commit;
    } jpst_cmd_t;

endpackage

[rtl/jpst_ctrl.sv]
// ----------------------------------------------------------------------------
// jpst_ctrl
// sequencer: load, square, sum, commit
// ----------------------------------------------------------------------------
module jpst_ctrl
    import jpst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output jpst_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_SUM    = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.square = (state_reg == ST_SQUARE);
    assign cmd.sum    = (state_reg == ST_SUM);
    assign cmd.commit = (state_reg == ST_COMMIT);

endmodule

[rtl/jpst_datapath.sv]
// ----------------------------------------------------------------------------
// jpst_datapath
// key arithmetic, sorted table with parallel shift insert, result register
// ----------------------------------------------------------------------------
module jpst_datapath
    import jpst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  jpst_cmd_t cmd,
    input  jet_in_t   item,
    output jet_out_t  result,
    output logic      result_valid
);

    `include "jet_priority_sorted_table_unit_defines.svh"

    localparam int MAG_BITS = MOM_BITS;
    localparam int SQ_BITS  = 2 * MAG_BITS;

    jet_in_t              item_reg;
    logic [SQ_BITS-1:0]   sqx_reg, sqy_reg, sqz_reg, sqe_reg;
    logic [KEY_BITS-1:0]  key_reg;

    logic signed [MOM_BITS-1:0] ent_px [MAX_JETS];
    logic signed [MOM_BITS-1:0] ent_py [MAX_JETS];
    logic signed [MOM_BITS-1:0] ent_pz [MAX_JETS];
    logic [MOM_BITS-2:0]        ent_e  [MAX_JETS];
    logic [7:0]                 ent_tag[MAX_JETS];
    logic                       ent_tg [MAX_JETS];
    logic [KEY_BITS-1:0]        ent_key[MAX_JETS];

    logic [CNT_BITS-1:0] held_reg, tagged_reg;
    jet_out_t            result_reg, result_next;
    logic                valid_reg;

    function automatic logic [MAG_BITS-1:0] mag(input logic signed [MOM_BITS-1:0] v);
        logic [MAG_BITS-1:0] r;
        r = v[MOM_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
        return r;
    endfunction

    // load, square and sum stages
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.square)
        begin
            sqx_reg <= SQ_BITS'(mag(item_reg.jet_px)) * SQ_BITS'(mag(item_reg.jet_px));
            sqy_reg <= SQ_BITS'(mag(item_reg.jet_py)) * SQ_BITS'(mag(item_reg.jet_py));
            sqz_reg <= SQ_BITS'(mag(item_reg.jet_pz)) * SQ_BITS'(mag(item_reg.jet_pz));
            sqe_reg <= SQ_BITS'(item_reg.jet_energy) * SQ_BITS'(item_reg.jet_energy);
        end
        if (cmd.sum)
        begin
            key_reg <= KEY_BITS'({2'b00, sqx_reg} + {2'b00, sqy_reg}
                       + ((sqe_reg >= sqz_reg) ? {2'b00, sqe_reg - sqz_reg}
                                               : {2'b00, sqz_reg - sqe_reg}));
        end
    end

    // priority compare per slot
    logic [MAX_JETS-1:0] ahead;
    logic [MAX_JETS-1:0] occupied;
    logic [MAX_JETS-1:0] shift;
    logic [CNT_BITS-1:0] pos;

    always_comb
    begin
        for (int i = 0; i < MAX_JETS; i++)
        begin
            occupied[i] = (CNT_BITS'(i) < held_reg);
            if (item_reg.jet_tag != ent_tag[i])
                ahead[i] = item_reg.jet_tag > ent_tag[i];
            else if (item_reg.jet_taggable != ent_tg[i])
                ahead[i] = item_reg.jet_taggable;
            else
                ahead[i] = key_reg > ent_key[i];
            ahead[i] = ahead[i] && occupied[i];
        end
        // first slot the new jet beats, and every slot after it, moves up
        shift[0] = ahead[0];
        for (int i = 1; i < MAX_JETS; i++)
        begin
            shift[i] = shift[i-1] || ahead[i];
        end
        pos = CNT_BITS'($countones(occupied & ~shift));
    end

    logic full;
    logic rd_ok;
    assign full  = (held_reg == CNT_BITS'(MAX_JETS));
    assign rd_ok = ({1'b0, item_reg.read_index} < held_reg);

    // table update
    always_ff @(posedge clk)
    begin
        if (cmd.commit && item_reg.mode == MODE_INSERT && !full)
        begin
            if (pos == '0)
            begin
                ent_px[0]  <= item_reg.jet_px;
                ent_py[0]  <= item_reg.jet_py;
                ent_pz[0]  <= item_reg.jet_pz;
                ent_e[0]   <= item_reg.jet_energy;
                ent_tag[0] <= item_reg.jet_tag;
                ent_tg[0]  <= item_reg.jet_taggable;
                ent_key[0] <= key_reg;
            end
            for (int i = 1; i < MAX_JETS; i++)
            begin
                if (CNT_BITS'(i) == pos)
                begin
                    ent_px[i]  <= item_reg.jet_px;
                    ent_py[i]  <= item_reg.jet_py;
                    ent_pz[i]  <= item_reg.jet_pz;
                    ent_e[i]   <= item_reg.jet_energy;
                    ent_tag[i] <= item_reg.jet_tag;
                    ent_tg[i]  <= item_reg.jet_taggable;
                    ent_key[i] <= key_reg;
                end
                else if (CNT_BITS'(i) > pos)
                begin
                    ent_px[i]  <= ent_px[i-1];
                    ent_py[i]  <= ent_py[i-1];
                    ent_pz[i]  <= ent_pz[i-1];
                    ent_e[i]   <= ent_e[i-1];
                    ent_tag[i] <= ent_tag[i-1];
                    ent_tg[i]  <= ent_tg[i-1];
                    ent_key[i] <= ent_key[i-1];
                end
            end
        end
    end

    always_comb
    begin
        result_next = '0;
        result_next.jet_count       = held_reg;
        result_next.bjet_count      = tagged_reg;
        result_next.insert_position = CNT_BITS'(MAX_JETS);
        case (item_reg.mode)
            MODE_CLEAR:
            begin
                result_next.jet_count  = '0;
                result_next.bjet_count = '0;
            end
            MODE_INSERT:
            begin
                if (full)
                begin
                    result_next.error_flag = 1'b1;
                end
                else
                begin
                    result_next.jet_count       = held_reg + CNT_BITS'(1);
                    result_next.bjet_count      = tagged_reg
                                                  + CNT_BITS'(item_reg.jet_tag != 8'd0);
                    result_next.insert_position = pos;
                end
            end
            MODE_READ:
            begin
                if (rd_ok)
                begin
                    result_next.out_px       = ent_px[item_reg.read_index];
                    result_next.out_py       = ent_py[item_reg.read_index];
                    result_next.out_pz       = ent_pz[item_reg.read_index];
                    result_next.out_energy   = ent_e[item_reg.read_index];
                    result_next.out_tag      = ent_tag[item_reg.read_index];
                    result_next.out_taggable = ent_tg[item_reg.read_index];
                end
                else
                begin
                    result_next.error_flag = 1'b1;
                end
            end
            default:
            begin
                result_next.error_flag = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            tagged_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.commit;
            if (cmd.commit)
            begin
                held_reg   <= result_next.jet_count;
                tagged_reg <= result_next.bjet_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

    `JPST_ASSERT_IMPL(a_held_bound, 1'b1, held_reg <= CNT_BITS'(MAX_JETS))
    `JPST_ASSERT_IMPL(a_tagged_bound, 1'b1, tagged_reg <= held_reg)
    `JPST_ASSERT_NEXT(a_valid_after_commit, cmd.commit, valid_reg)
    `JPST_ASSERT_NEXT(a_full_refused,
        cmd.commit && item_reg.mode == MODE_INSERT && full, result_reg.error_flag)

endmodule

[rtl/jet_priority_sorted_table_unit.sv]
// ----------------------------------------------------------------------------
// jet_priority_sorted_table_unit
// table of up to 16 jets kept sorted by tag, taggable flag and pt2+mt2 key
//
// channel  | direction | handshake           | payload
// item     | in        | start, busy         | item (jet_in_t)
// result   | out       | done strobe         | result (jet_out_t)
//
// every item passes through load, square, key sum, compare and shift insert
// done pulses in the cycle after the commit cycle; busy is low again then
// the four squarings in one stage and the key adder set the item latency
// reset empties the table; entry contents are not cleared
// the receiver cannot stall; results are valid for one cycle only
// ----------------------------------------------------------------------------
module jet_priority_sorted_table_unit
    import jpst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  jet_in_t  item,
    output logic     done,
    output jet_out_t result
);

    jpst_cmd_t cmd;

    jpst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    jpst_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .result       (result),
        .result_valid (done)
    );

endmodule
